>>> hw/rtl/rlf_pkg.sv
`timescale 1ns / 1ps

package rlf_pkg;

    localparam int HOLD_TICKS_DEF      = 10;
    localparam int PRE_DELAY_TICKS_DEF = 10;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CD_W       = 17;

    localparam logic [11:0] CTRL_MARGIN = 12'd100;
    localparam logic [11:0] THR_MARGIN  = 12'd50;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODEM_MODE       = 8'd0,
        REG_CTRL_PULSE_MAX   = 8'd1,
        REG_THR_PULSE_MIN    = 8'd2,
        REG_FAILSAFE_DELAY   = 8'd3,
        REG_RF_LOST_LIMIT    = 8'd4,
        REG_MODEM_CRC_LIMIT  = 8'd5,
        REG_MODEM_LOST_LIMIT = 8'd6,
        REG_SWITCH_THRESHOLD = 8'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        STATUS_NORMAL       = 3'd0,
        STATUS_HOLD         = 3'd1,
        STATUS_STABILISE    = 3'd2,
        STATUS_NO_STABILISE = 3'd3,
        STATUS_AUTOPILOT    = 3'd4,
        STATUS_NO_AUTOPILOT = 3'd5
    } status_t;

    typedef struct packed {
        logic        modem_mode;
        logic [11:0] ctrl_pulse_max;
        logic [11:0] thr_pulse_min;
        logic [15:0] failsafe_delay_tenths;
        logic [7:0]  rf_lost_limit;
        logic [7:0]  modem_crc_limit;
        logic [7:0]  modem_lost_limit;
        logic [11:0] switch_threshold;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  rf_lost_count;
        logic        pulse_hold;
        logic [11:0] ctrl_pulse;
        logic [11:0] thr_pulse;
        logic [7:0]  modem_crc_errors;
        logic [7:0]  modem_lost_count;
    } tick_t;

    typedef struct packed {
        logic hold;
        logic rf;
        logic pos;
        logic modem;
    } fault_t;

    typedef struct packed {
        logic               failsafe_active;
        status_t            failsafe_status;
        logic signed [CD_W-1:0] countdown_tenths;
    } result_t;

endpackage

>>> hw/rtl/rlf_qual.sv
`timescale 1ns / 1ps

module rlf_qual #(
    parameter int HOLD_TICKS = rlf_pkg::HOLD_TICKS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  rlf_pkg::cfg_t  cfg,
    input  rlf_pkg::tick_t tick,
    output rlf_pkg::fault_t faults
);
    import rlf_pkg::*;

    localparam int HoldW = $clog2(HOLD_TICKS + 1);

    logic [HoldW-1:0] hold_cnt_reg;
    logic [HoldW-1:0] hold_cnt_next;
    logic             hold_fault;
    logic             ctrl_high;
    logic             thr_low;

    always_comb
    begin
        hold_cnt_next = hold_cnt_reg;
        hold_fault    = 1'b0;
        if (tick.pulse_hold)
        begin
            if (hold_cnt_reg < HoldW'(HOLD_TICKS))
            begin
                hold_cnt_next = hold_cnt_reg + 1'b1;
            end
            else
            begin
                hold_fault = 1'b1;
            end
        end
        else
        begin
            hold_cnt_next = '0;
        end
    end

    // The throttle test is rearranged so that a minimum below the margin never trips.
    assign ctrl_high = {1'b0, tick.ctrl_pulse} >
                       ({1'b0, cfg.ctrl_pulse_max} + {1'b0, CTRL_MARGIN});
    assign thr_low   = ({1'b0, tick.thr_pulse} + {1'b0, THR_MARGIN}) < {1'b0, cfg.thr_pulse_min};

    assign faults.hold  = hold_fault;
    assign faults.rf    = tick.rf_lost_count > cfg.rf_lost_limit;
    assign faults.pos   = cfg.modem_mode ? thr_low : (ctrl_high || thr_low);
    assign faults.modem = cfg.modem_mode &&
                          ((tick.modem_crc_errors > cfg.modem_crc_limit) ||
                           (tick.modem_lost_count > cfg.modem_lost_limit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt_reg <= '0;
        end
        else if (advance)
        begin
            hold_cnt_reg <= hold_cnt_next;
        end
    end

endmodule

>>> hw/rtl/rlf_fsm.sv
`timescale 1ns / 1ps

module rlf_fsm #(
    parameter int PRE_DELAY_TICKS = rlf_pkg::PRE_DELAY_TICKS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  rlf_pkg::cfg_t   cfg,
    input  logic [11:0]     ctrl_pulse,
    input  rlf_pkg::fault_t faults,
    output rlf_pkg::result_t result
);
    import rlf_pkg::*;

    localparam int PreW = $clog2(PRE_DELAY_TICKS + 1);

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_PRE    = 2'd1,
        ST_STAB   = 2'd2,
        ST_AUTO   = 2'd3
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [PreW-1:0]        pre_cnt_reg;
    logic [PreW-1:0]        pre_cnt_next;
    logic signed [CD_W-1:0] countdown_reg;
    logic signed [CD_W-1:0] countdown_next;
    logic                   fail;
    logic                   link_fault;
    status_t                status;

    assign fail       = faults.hold || faults.rf || faults.pos || faults.modem;
    assign link_fault = faults.hold || faults.rf || faults.pos;

    always_comb
    begin
        state_next     = state_reg;
        pre_cnt_next   = pre_cnt_reg;
        countdown_next = countdown_reg;
        status         = STATUS_NORMAL;
        case (state_reg)
            ST_NORMAL:
            begin
                pre_cnt_next = '0;
                if (fail)
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (!fail)
                begin
                    state_next = ST_NORMAL;
                end
                else if (pre_cnt_reg < PreW'(PRE_DELAY_TICKS))
                begin
                    pre_cnt_next = pre_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next     = ST_STAB;
                    countdown_next = {1'b0, cfg.failsafe_delay_tenths};
                end
                status = (faults.hold || faults.rf) ? STATUS_HOLD : STATUS_NORMAL;
            end
            ST_STAB:
            begin
                if (!fail)
                begin
                    state_next = ST_NORMAL;
                end
                else if (!countdown_reg[CD_W-1])
                begin
                    countdown_next = countdown_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_AUTO;
                end
                status = link_fault ? STATUS_STABILISE : STATUS_NO_STABILISE;
            end
            ST_AUTO:
            begin
                if (!fail)
                begin
                    state_next = ST_NORMAL;
                end
                if (link_fault || (ctrl_pulse < cfg.switch_threshold))
                begin
                    status = STATUS_AUTOPILOT;
                end
                else
                begin
                    status = STATUS_NO_AUTOPILOT;
                end
            end
            default:
            begin
                state_next = ST_NORMAL;
            end
        endcase
    end

    assign result.failsafe_active  = fail;
    assign result.failsafe_status  = status;
    assign result.countdown_tenths = countdown_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_NORMAL;
            pre_cnt_reg   <= '0;
            countdown_reg <= '0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            pre_cnt_reg   <= pre_cnt_next;
            countdown_reg <= countdown_next;
        end
    end

endmodule

>>> hw/rtl/radio_link_failsafe_fsm.sv
`timescale 1ns / 1ps

// Channel   Direction  Item contents
// s_axis    in         one control tick (tdata, tuser = pulse_hold)
// m_axis    out        one failsafe result per tick
// cfg       in         register index and write data
//
// Each item passes an input register and a result register, with the fault
// qualification and state update sitting between the two registers; one item is
// taken per cycle while the output is drained. A stall at the output holds the
// result and, once the input register is full, drops s_tready.
// Reset clears the valid flags, the state machine and the hold counter and loads
// register defaults; the tick and result data registers are not reset.

module radio_link_failsafe_fsm #(
    parameter int HOLD_TICKS      = rlf_pkg::HOLD_TICKS_DEF,
    parameter int PRE_DELAY_TICKS = rlf_pkg::PRE_DELAY_TICKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rf_lost_count[7:0], ctrl_pulse[19:8], thr_pulse[31:20],
    // modem_crc_errors[39:32], modem_lost_count[47:40]
    input  logic [47:0]                    s_tdata,
    // pulse_hold[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // failsafe_active[0], failsafe_status[3:1], countdown_tenths[20:4], zero fill [23:21]
    output logic [23:0]                    m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rlf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rlf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rlf_pkg::*;

    cfg_t    cfg_reg;
    tick_t   tick_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;
    fault_t  faults;
    result_t result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modem_mode            <= 1'b0;
            cfg_reg.ctrl_pulse_max        <= 12'd2000;
            cfg_reg.thr_pulse_min         <= 12'd1000;
            cfg_reg.failsafe_delay_tenths <= 16'd0;
            cfg_reg.rf_lost_limit         <= 8'd10;
            cfg_reg.modem_crc_limit       <= 8'd10;
            cfg_reg.modem_lost_limit      <= 8'd10;
            cfg_reg.switch_threshold      <= 12'd1500;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                REG_MODEM_MODE:       cfg_reg.modem_mode            <= cfg_data[0];
                REG_CTRL_PULSE_MAX:   cfg_reg.ctrl_pulse_max        <= cfg_data[11:0];
                REG_THR_PULSE_MIN:    cfg_reg.thr_pulse_min         <= cfg_data[11:0];
                REG_FAILSAFE_DELAY:   cfg_reg.failsafe_delay_tenths <= cfg_data;
                REG_RF_LOST_LIMIT:    cfg_reg.rf_lost_limit         <= cfg_data[7:0];
                REG_MODEM_CRC_LIMIT:  cfg_reg.modem_crc_limit       <= cfg_data[7:0];
                REG_MODEM_LOST_LIMIT: cfg_reg.modem_lost_limit      <= cfg_data[7:0];
                REG_SWITCH_THRESHOLD: cfg_reg.switch_threshold      <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            tick_reg.rf_lost_count    <= s_tdata[7:0];
            tick_reg.ctrl_pulse       <= s_tdata[19:8];
            tick_reg.thr_pulse        <= s_tdata[31:20];
            tick_reg.modem_crc_errors <= s_tdata[39:32];
            tick_reg.modem_lost_count <= s_tdata[47:40];
            tick_reg.pulse_hold       <= s_tuser;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    rlf_qual #(
        .HOLD_TICKS (HOLD_TICKS)
    ) u_qual (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .tick    (tick_reg),
        .faults  (faults)
    );

    rlf_fsm #(
        .PRE_DELAY_TICKS (PRE_DELAY_TICKS)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg_reg),
        .ctrl_pulse (tick_reg.ctrl_pulse),
        .faults     (faults),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.countdown_tenths, out_reg.failsafe_status,
                       out_reg.failsafe_active};

endmodule
